// ===== rtl/chte_pkg.sv =====
// Shared types and codes for the chained hash table engine.
package chte_pkg;

   // Request opcodes.
   typedef enum logic [1:0] {
      OP_PUT = 2'd0,
      OP_ADD = 2'd1,
      OP_POP = 2'd2,
      OP_GET = 2'd3
   } op_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_FOUND     = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   // Datapath commands issued by the controller.
   typedef struct packed {
      logic start;      // latch request, begin modulo
      logic mod_step;   // one step of the bucket reduction
      logic head_rd;    // read bucket head
      logic head_load;  // load cur from head read data
      logic ent_rd;     // read entry at cur
      logic ent_adv;    // move prev/cur along the chain
      logic hit_mark;   // record that the entry at cur holds the key
      logic commit;     // perform the update for the decided case
      logic clear_sweep;// clear one bucket head
      logic rsp_load;   // load output register
   } cmd_type;

   // Status returned to the controller.
   typedef struct packed {
      logic mod_done;
      logic cur_nil;
      logic walk_limit;
      logic key_hit;
      logic sweep_done;
   } stat_type;

endpackage

// ===== rtl/chte_ctrl.sv =====
// Controller state machine for the chained hash table engine.
module chte_ctrl
   import chte_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_fire,
   input  logic     rsp_busy,
   input  stat_type stat,
   output logic     idle,
   output cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_MOD   = 8'b0000_0100,
      S_HEAD  = 8'b0000_1000,
      S_HLOAD = 8'b0001_0000,
      S_ERD   = 8'b0010_0000,
      S_ECHK  = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_sweep = 1'b1;
            if (stat.sweep_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd.start = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_done) state_in = S_HEAD;
         end
         S_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in = S_HLOAD;
         end
         S_HLOAD: begin
            cmd.head_load = 1'b1;
            state_in = S_ERD;
         end
         S_ERD: begin
            if (stat.cur_nil || stat.walk_limit) state_in = S_DONE;
            else begin
               cmd.ent_rd = 1'b1;
               state_in = S_ECHK;
            end
         end
         S_ECHK: begin
            if (stat.key_hit) begin
               cmd.hit_mark = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.ent_adv = 1'b1;
               state_in = S_ERD;
            end
         end
         S_DONE: begin
            if (!rsp_busy) begin
               cmd.commit = 1'b1;
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

   assign idle = (state_ff == S_IDLE);

endmodule

// ===== rtl/chte_dp.sv =====
// Datapath of the chained hash table engine: memories, pointers and update logic.
module chte_dp
   import chte_pkg::*;
#(
   parameter int BUCKETS     = 53,
   parameter int ENTRIES     = 38,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32,
   parameter int MAX_CHAIN   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic [1:0]             req_opcode,
   input  logic [KEY_WIDTH-1:0]   req_key,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic [2:0]             res_status,
   output logic [VALUE_WIDTH-1:0] res_value,
   output logic [5:0]             res_count
);

   localparam int PW = $clog2(ENTRIES + 1);
   localparam int BW = $clog2(BUCKETS);
   localparam int EW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [PW-1:0] NIL = PW'(ENTRIES);
   // Bucket reduction works on key bytes, most significant first.
   localparam int NCH = (KEY_WIDTH + 7) / 8;
   localparam int IW  = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int VW  = BW + 8;
   localparam int MW  = VW + 2;
   localparam int SH  = VW + BW;
   localparam longint unsigned RECIP =
      ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

   // Memories.
   logic [PW-1:0]          heads_mem [BUCKETS];
   logic [KEY_WIDTH-1:0]   keys_mem  [ENTRIES];
   logic [VALUE_WIDTH-1:0] vals_mem  [ENTRIES];
   logic [PW-1:0]          links_mem [ENTRIES];

   // Request and walk registers.
   op_type                 op_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic [NCH*8-1:0]       key_sh_ff;
   logic [BW-1:0]          rem_ff;
   logic [VW-1:0]          mix_ff;
   logic [7:0]             quo_ff;
   logic [IW-1:0]          byte_ff;
   logic                   half_ff;
   logic [PW-1:0]          cur_ff, prev_ff, hrd_ff, free_ff, hw_ff, cnt_ff;
   logic [PW-1:0]          links_rd_ff;
   logic [KEY_WIDTH-1:0]   keys_rd_ff;
   logic [VALUE_WIDTH-1:0] vals_rd_ff;
   logic [CW-1:0]          len_ff;
   logic                   found_ff;
   logic [BW-1:0]          sweep_ff;
   logic [PW-1:0]          free_link_ff;

   logic [BW-1:0] bucket;
   assign bucket = rem_ff;

   // Bucket reduction: per key byte, the quotient of {remainder, byte} comes from a
   // reciprocal multiplication and is registered, then the new remainder follows from it.
   logic [VW-1:0]    mix;
   logic [VW+MW-1:0] prod;
   assign mix  = {rem_ff, key_sh_ff[NCH*8-1 -: 8]};
   assign prod = (VW+MW)'(mix) * (VW+MW)'(MW'(RECIP));
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff     <= op_type'(req_opcode);
         key_ff    <= req_key;
         val_ff    <= req_value;
         key_sh_ff <= (NCH*8)'(req_key);
         rem_ff    <= '0;
         byte_ff   <= '0;
         half_ff   <= 1'b0;
      end else if (cmd.mod_step) begin
         if (!half_ff) begin
            mix_ff    <= mix;
            quo_ff    <= prod[SH +: 8];
            key_sh_ff <= key_sh_ff << 8;
            half_ff   <= 1'b1;
         end else begin
            rem_ff  <= BW'(mix_ff - VW'(quo_ff) * VW'(BUCKETS));
            byte_ff <= byte_ff + 1'b1;
            half_ff <= 1'b0;
         end
      end
   end
   assign stat.mod_done = cmd.mod_step && half_ff && (32'(byte_ff) == NCH - 1);

   // Chain walk.
   always_ff @(posedge clock) begin
      if (cmd.head_rd) hrd_ff <= heads_mem[bucket];
      if (cmd.ent_rd) begin
         keys_rd_ff  <= keys_mem[cur_ff[EW-1:0]];
         vals_rd_ff  <= vals_mem[cur_ff[EW-1:0]];
         links_rd_ff <= links_mem[cur_ff[EW-1:0]];
      end
      if (cmd.head_load) begin
         cur_ff  <= hrd_ff;
         prev_ff <= NIL;
         len_ff  <= '0;
         found_ff <= 1'b0;
      end else if (cmd.ent_rd) begin
         found_ff <= 1'b0;
      end else if (cmd.ent_adv) begin
         prev_ff <= cur_ff;
         cur_ff  <= links_rd_ff;
         len_ff  <= len_ff + 1'b1;
      end else if (cmd.hit_mark) begin
         found_ff <= 1'b1;
      end
   end
   assign stat.cur_nil    = (cur_ff >= NIL);
   assign stat.walk_limit = (32'(len_ff) >= ENTRIES);
   assign stat.key_hit    = (keys_rd_ff == key_ff) && !found_ff;

   // Free list head link read, done during the walk.
   always_ff @(posedge clock) begin
      if (cmd.head_load && free_ff < NIL) free_link_ff <= links_mem[free_ff[EW-1:0]];
   end

   // Decision for the commit.
   logic is_ins, is_pop, full, hit, free_avail;
   logic [PW-1:0] new_idx;
   assign hit        = found_ff;
   assign free_avail = (free_ff < NIL);
   assign full = (32'(len_ff) > MAX_CHAIN) || (!free_avail && 32'(hw_ff) >= ENTRIES);
   assign is_ins = (op_ff == OP_PUT || op_ff == OP_ADD) && !hit && !full;
   assign is_pop = (op_ff == OP_POP) && hit;
   assign new_idx = free_avail ? free_ff : hw_ff;

   logic [PW-1:0] cnt_dec;
   assign cnt_dec = (cnt_ff != '0) ? cnt_ff - 1'b1 : cnt_ff;

   // Unlink from a predecessor needs a second link write; done the cycle after commit.
   logic             fix_ff;
   logic [PW-1:0]    fix_idx_ff, fix_val_ff;
   always_ff @(posedge clock) begin
      if (reset) fix_ff <= 1'b0;
      else fix_ff <= cmd.commit && is_pop && prev_ff < NIL;
      fix_idx_ff <= prev_ff;
      fix_val_ff <= links_rd_ff;
   end

   // Memory and pointer updates.
   always_ff @(posedge clock) begin
      if (cmd.clear_sweep) heads_mem[sweep_ff] <= NIL;
      else if (cmd.commit && is_ins) heads_mem[bucket] <= new_idx;
      else if (cmd.commit && is_pop && prev_ff >= NIL) heads_mem[bucket] <= links_rd_ff;
      if (cmd.commit && is_ins) begin
         keys_mem[new_idx[EW-1:0]]  <= key_ff;
         vals_mem[new_idx[EW-1:0]]  <= val_ff;
         links_mem[new_idx[EW-1:0]] <= hrd_ff;
      end else if (cmd.commit && hit && op_ff == OP_PUT) begin
         vals_mem[cur_ff[EW-1:0]] <= val_ff;
      end else if (cmd.commit && is_pop) begin
         links_mem[cur_ff[EW-1:0]] <= free_ff;
      end else if (fix_ff) begin
         links_mem[fix_idx_ff[EW-1:0]] <= fix_val_ff;
      end
   end

   // Sweep, free list, high-water mark and count.
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         free_ff  <= NIL;
         hw_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         if (cmd.clear_sweep) sweep_ff <= sweep_ff + 1'b1;
         if (cmd.commit && is_ins) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (free_avail) free_ff <= free_link_ff;
            else hw_ff <= hw_ff + 1'b1;
         end else if (cmd.commit && is_pop) begin
            cnt_ff <= cnt_dec;
            if (cnt_dec == '0) begin
               free_ff <= NIL;
               hw_ff   <= '0;
            end else begin
               free_ff <= cur_ff;
            end
         end
      end
   end
   assign stat.sweep_done = (32'(sweep_ff) == BUCKETS - 1);

   // Result register contents.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         res_value <= '0;
         if (op_ff == OP_PUT || op_ff == OP_ADD) begin
            if (hit) begin
               res_status <= (op_ff == OP_ADD) ? ST_DUPLICATE : ST_FOUND;
               if (op_ff == OP_PUT) res_value <= vals_rd_ff;
            end else if (full) res_status <= ST_FULL;
            else res_status <= ST_INSERTED;
            res_count <= 6'(is_ins ? cnt_ff + 1'b1 : cnt_ff);
         end else begin
            res_status <= hit ? ST_FOUND : ST_NOT_FOUND;
            if (hit) res_value <= vals_rd_ff;
            res_count <= 6'(is_pop ? cnt_dec : cnt_ff);
         end
      end
   end

endmodule

// ===== rtl/chained_hash_table_engine_core.sv =====
// Top level of the chained hash table engine.
// A key-value table kept as bucket chains over a fixed entry pool.
// Input channel req_*: one request per transfer, opcode put, add, pop or get.
// Result channel rsp_*: exactly one result per request, in order.
// Each request reduces the key to a bucket one key byte at a time, reads the
// bucket head, examines the chain entries one at a time, makes a final check
// when the walk ends without a match, and then commits.
// Requests are handled one at a time; the result is valid the cycle after commit.
// The result sits in an output register; a new request is taken while it
// waits, and the next commit waits until that result is transferred.
// After reset the block clears its BUCKETS bucket heads, one per cycle,
// and accepts no request until all of them are cleared.
// A stalled receiver simply holds rsp_tvalid and the result stable.
module chained_hash_table_engine_core
   import chte_pkg::*;
#(
   parameter int BUCKETS     = 53,
   parameter int ENTRIES     = 38,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32,
   parameter int MAX_CHAIN   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // opcode[1:0], key[33:2], value[65:34], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // status[2:0], value_out[34:3], stored_count[40:35], pad
);

   cmd_type  cmd;
   stat_type stat;
   logic     idle, req_fire, rsp_valid_ff;
   logic [2:0]             res_status;
   logic [VALUE_WIDTH-1:0] res_value;
   logic [5:0]             res_count;

   assign req_tready = idle;
   assign req_fire   = req_tvalid && req_tready;

   chte_ctrl u_ctrl (
      .clock, .reset, .req_fire,
      .rsp_busy(rsp_valid_ff && !rsp_tready),
      .stat, .idle, .cmd
   );

   chte_dp #(
      .BUCKETS(BUCKETS), .ENTRIES(ENTRIES), .KEY_WIDTH(KEY_WIDTH),
      .VALUE_WIDTH(VALUE_WIDTH), .MAX_CHAIN(MAX_CHAIN)
   ) u_dp (
      .clock, .reset, .cmd, .stat,
      .req_opcode(req_tdata[1:0]),
      .req_key(KEY_WIDTH'(req_tdata[33:2])),
      .req_value(VALUE_WIDTH'(req_tdata[65:34])),
      .res_status, .res_value, .res_count
   );

   // Output valid flag.
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, res_count, 32'(res_value), res_status};

endmodule
